// ===== design/tbo_pkg.sv =====
// Shared widths, codes, types and the index helper of the triangle box overlap test.
package tbo_pkg;

	localparam int CW = 32;      // coordinate width
	localparam int HW = 31;      // half size width
	localparam int TW = CW + 1;  // vertex minus centre
	localparam int VW = CW + 3;  // plane test box corner offsets
	localparam int PW = 2 * TW + 2;  // projections and dot products

	localparam logic [2:0] CMD_LOAD_V0 = 3'd0;
	localparam logic [2:0] CMD_LOAD_V1 = 3'd1;
	localparam logic [2:0] CMD_LOAD_V2 = 3'd2;
	localparam logic [2:0] CMD_LOAD_N  = 3'd3;
	localparam logic [2:0] CMD_TEST    = 3'd4;

	localparam logic [1:0] REG_HALF_X = 2'd0;
	localparam logic [1:0] REG_HALF_Y = 2'd1;
	localparam logic [1:0] REG_HALF_Z = 2'd2;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [TW-1:0] tval_t;
	typedef logic signed [PW-1:0] wide_t;
	typedef logic [HW-1:0] half_t;

	typedef struct packed {
		logic valid;
		tval_t [2:0][2:0] t;   // [vertex][axis]
		coord_t [2:0] n;
	} front_t;

	typedef struct packed {
		logic valid;
		logic boxfail;
		wide_t [2:0][2:0] pa;  // [box axis][edge]
		wide_t [2:0][2:0] pb;
		wide_t [2:0][2:0] r;
		wide_t dmin;
		wide_t dmax;
	} arith_t;

	// Next index in the cyclic order 0, 1, 2.
	function automatic logic [1:0] nxt(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : 2'(i + 2'd1);
	endfunction

endpackage

// ===== design/tbo_front.sv =====
// Triangle vertex and normal store, and the first stage that forms vertex minus centre.
module tbo_front import tbo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       en,
	input  logic [2:0] command,
	input  coord_t     coord_x,
	input  coord_t     coord_y,
	input  coord_t     coord_z,
	output front_t     s1
);

	coord_t vert_q [9];
	coord_t norm_q [3];
	coord_t cen [3];
	logic   valid_s1;
	tval_t  t_s1 [3][3];
	coord_t n_s1 [3];

	assign cen[0] = coord_x;
	assign cen[1] = coord_y;
	assign cen[2] = coord_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) vert_q[i] <= '0;
			for (int i = 0; i < 3; i++) norm_q[i] <= '0;
		end else if (accept) begin
			unique case (command)
				CMD_LOAD_V0: for (int k = 0; k < 3; k++) vert_q[k] <= cen[k];
				CMD_LOAD_V1: for (int k = 0; k < 3; k++) vert_q[3 + k] <= cen[k];
				CMD_LOAD_V2: for (int k = 0; k < 3; k++) vert_q[6 + k] <= cen[k];
				CMD_LOAD_N:  for (int k = 0; k < 3; k++) norm_q[k] <= cen[k];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept && (command == CMD_TEST);
		end
	end

	// The test item takes a snapshot of the triangle, so later loads do not disturb it.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					t_s1[i][k] <= TW'(vert_q[3 * i + k]) - TW'(cen[k]);
				end
			end
			for (int k = 0; k < 3; k++) n_s1[k] <= norm_q[k];
		end
	end

	always_comb begin
		s1.valid = valid_s1;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) s1.t[i][k] = t_s1[i][k];
			s1.n[i] = n_s1[i];
		end
	end

endmodule

// ===== design/tbo_arith.sv =====
// Edges, box axis test, products and sums of the plane and edge axis projections.
module tbo_arith import tbo_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  half_t  half [3],
	input  front_t s1,
	output arith_t s4
);

	// Stage 2 comb
	tval_t               e [3][3];
	logic [CW-1:0]       ae [3][3];
	logic signed [VW-1:0] vmin [3];
	logic signed [VW-1:0] vmax [3];
	logic                boxfail;

	always_comb begin
		logic signed [TW:0] d;
		logic signed [TW:0] x;
		logic signed [TW:0] hs;
		logic signed [VW-1:0] vn;
		logic signed [VW-1:0] vp;
		logic above;
		logic below;
		boxfail = 1'b0;
		for (int ed = 0; ed < 3; ed++) begin
			for (int c = 0; c < 3; c++) begin
				d = (TW+1)'(s1.t[nxt(2'(ed))][c]) - (TW+1)'(s1.t[ed][c]);
				e[ed][c] = d[TW-1:0];
				x = (TW+1)'(e[ed][c]);
				x = x[TW] ? -x : x;
				ae[ed][c] = x[CW-1:0];
			end
		end
		for (int k = 0; k < 3; k++) begin
			hs = $signed({3'b000, half[k]});
			above = 1'b1;
			below = 1'b1;
			for (int i = 0; i < 3; i++) begin
				above = above && ((TW+1)'(s1.t[i][k]) > hs);
				below = below && ((TW+1)'(s1.t[i][k]) < -hs);
			end
			boxfail = boxfail || above || below;
			vn = -$signed(VW'({1'b0, half[k]})) - VW'(s1.t[0][k]);
			vp = $signed(VW'({1'b0, half[k]})) - VW'(s1.t[0][k]);
			if ($signed(s1.n[k]) > 0) begin
				vmin[k] = vn;
				vmax[k] = vp;
			end else begin
				vmin[k] = vp;
				vmax[k] = vn;
			end
		end
	end

	logic                 valid_s2, boxfail_s2;
	tval_t                e_s2 [3][3];
	logic [CW-1:0]        ae_s2 [3][3];
	tval_t                t_s2 [3][3];
	coord_t               n_s2 [3];
	logic signed [VW-1:0] vmin_s2 [3];
	logic signed [VW-1:0] vmax_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			boxfail_s2 <= boxfail;
			for (int i = 0; i < 3; i++) begin
				for (int c = 0; c < 3; c++) begin
					e_s2[i][c]  <= e[i][c];
					ae_s2[i][c] <= ae[i][c];
					t_s2[i][c]  <= s1.t[i][c];
				end
				n_s2[i]    <= s1.n[i];
				vmin_s2[i] <= vmin[i];
				vmax_s2[i] <= vmax[i];
			end
		end
	end

	// Stage 3: products. Both ends of an edge project to the same value on its cross axis,
	// so only the edge start and the opposite vertex are projected.
	logic                 valid_s3, boxfail_s3;
	logic signed [2*TW-1:0] q1_s3 [3][3];
	logic signed [2*TW-1:0] q2_s3 [3][3];
	logic signed [2*TW-1:0] q3_s3 [3][3];
	logic signed [2*TW-1:0] q4_s3 [3][3];
	logic [HW+CW-1:0]       r1_s3 [3][3];
	logic [HW+CW-1:0]       r2_s3 [3][3];
	logic signed [CW+VW-1:0] pmin_s3 [3];
	logic signed [CW+VW-1:0] pmax_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic [1:0] u;
		logic [1:0] w;
		logic [1:0] m;
		if (en) begin
			boxfail_s3 <= boxfail_s2;
			for (int k = 0; k < 3; k++) begin
				u = nxt(2'(k));
				w = nxt(u);
				for (int ed = 0; ed < 3; ed++) begin
					m = nxt(nxt(2'(ed)));
					q1_s3[k][ed] <= e_s2[ed][w] * t_s2[ed][u];
					q2_s3[k][ed] <= e_s2[ed][u] * t_s2[ed][w];
					q3_s3[k][ed] <= e_s2[ed][w] * t_s2[m][u];
					q4_s3[k][ed] <= e_s2[ed][u] * t_s2[m][w];
					r1_s3[k][ed] <= half[u] * ae_s2[ed][w];
					r2_s3[k][ed] <= half[w] * ae_s2[ed][u];
				end
				pmin_s3[k] <= n_s2[k] * vmin_s2[k];
				pmax_s3[k] <= n_s2[k] * vmax_s2[k];
			end
		end
	end

	// Stage 4: sums.
	logic  valid_s4, boxfail_s4;
	wide_t pa_s4 [3][3];
	wide_t pb_s4 [3][3];
	wide_t r_s4 [3][3];
	wide_t dmin_s4, dmax_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			boxfail_s4 <= boxfail_s3;
			for (int k = 0; k < 3; k++) begin
				for (int ed = 0; ed < 3; ed++) begin
					pa_s4[k][ed] <= PW'(q2_s3[k][ed]) - PW'(q1_s3[k][ed]);
					pb_s4[k][ed] <= PW'(q4_s3[k][ed]) - PW'(q3_s3[k][ed]);
					r_s4[k][ed]  <= $signed(PW'(r1_s3[k][ed]) + PW'(r2_s3[k][ed]));
				end
			end
			dmin_s4 <= PW'(pmin_s3[0]) + PW'(pmin_s3[1]) + PW'(pmin_s3[2]);
			dmax_s4 <= PW'(pmax_s3[0]) + PW'(pmax_s3[1]) + PW'(pmax_s3[2]);
		end
	end

	always_comb begin
		s4.valid   = valid_s4;
		s4.boxfail = boxfail_s4;
		for (int k = 0; k < 3; k++) begin
			for (int ed = 0; ed < 3; ed++) begin
				s4.pa[k][ed] = pa_s4[k][ed];
				s4.pb[k][ed] = pb_s4[k][ed];
				s4.r[k][ed]  = r_s4[k][ed];
			end
		end
		s4.dmin = dmin_s4;
		s4.dmax = dmax_s4;
	end

endmodule

// ===== design/tbo_judge.sv =====
// Final compares, result register and skid buffer on the result channel.
module tbo_judge import tbo_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  arith_t s4,
	input  logic   result_stall,
	output logic   result_valid,
	output logic   overlap,
	output logic   en
);

	logic fail;

	always_comb begin
		logic signed [PW-1:0] rr;
		logic signed [PW-1:0] a;
		logic signed [PW-1:0] b;
		fail = s4.boxfail || ($signed(s4.dmin) > 0) || ($signed(s4.dmax) < 0);
		for (int k = 0; k < 3; k++) begin
			for (int ed = 0; ed < 3; ed++) begin
				rr = $signed(s4.r[k][ed]);
				a  = $signed(s4.pa[k][ed]);
				b  = $signed(s4.pb[k][ed]);
				fail = fail || (a > rr && b > rr) || (a < -rr && b < -rr);
			end
		end
	end

	logic valid_s5, overlap_s5;
	logic out_valid_q, out_q;
	logic skid_valid_q, skid_q;
	logic take;

	assign en   = !skid_valid_q;
	assign take = out_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) overlap_s5 <= !fail;
	end

	// A result that meets a stalled output register parks in the skid slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) skid_valid_q <= 1'b0;
		end else if (valid_s5) begin
			if (!out_valid_q || take) out_valid_q <= 1'b1;
			else skid_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) out_q <= skid_q;
		end else if (valid_s5) begin
			if (!out_valid_q || take) out_q <= overlap_s5;
			else skid_q <= overlap_s5;
		end
	end

	assign result_valid = out_valid_q;
	assign overlap      = out_q;

endmodule

// ===== design/triangle_box_overlap_test_unit.sv =====
// Top level of the pipelined triangle versus axis-aligned box overlap test.
//
// Items arrive on the item channel (item_valid, item_stall). Commands 0 to 2
// load one triangle vertex, command 3 loads the plane normal, and command 4
// tests a box centred at the given coordinates; only a test makes a result.
// Results leave on the result channel (result_valid, result_stall) as one
// overlap flag each, in the order of the test items.
// Box half sizes are written through cfg_we, cfg_index and cfg_data; indexes above
// two are ignored. They are to be written only while the block is idle; the user
// is bound to this, and the block itself does not enforce it. A test item enters
// every cycle while item_stall is low. Its flag passes the vertex minus centre
// stage, loaded at the transfer, then one stage for edges and the box axes, one for
// the multipliers, one for the sums, one for the compares, and the output register.
// When the receiver stalls, one more result is held in a skid slot; item_stall
// rises only while that slot is full, and the whole pipeline then holds.
// Reset clears the triangle, the normal, the half sizes and all valid bits.
module triangle_box_overlap_test_unit import tbo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  command,
	input  coord_t      coord_x,
	input  coord_t      coord_y,
	input  coord_t      coord_z,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        overlap,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [HW-1:0] cfg_data
);

	half_t  half_q [3];
	logic   en;
	logic   accept;
	front_t s1;
	arith_t s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) half_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF_X: half_q[0] <= cfg_data;
				REG_HALF_Y: half_q[1] <= cfg_data;
				REG_HALF_Z: half_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item_stall = !en;
	assign accept     = item_valid && en;

	tbo_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.en      (en),
		.command (command),
		.coord_x (coord_x),
		.coord_y (coord_y),
		.coord_z (coord_z),
		.s1      (s1)
	);

	tbo_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.half   (half_q),
		.s1     (s1),
		.s4     (s4)
	);

	tbo_judge u_judge (
		.clk          (clk),
		.arst_n       (arst_n),
		.s4           (s4),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.overlap      (overlap),
		.en           (en)
	);

endmodule

// ===== design/tbo_checker.sv =====
// Port level checks of the overlap test unit and the bind that attaches them.
module tbo_checker (
	input logic clk,
	input logic arst_n,
	input logic item_stall,
	input logic result_valid,
	input logic result_stall,
	input logic overlap
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(overlap))
		else $error("stalled result changed");

	// Input back-pressure only comes from a full skid slot behind a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("item stall without a waiting result");

	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall && result_stall |=> item_stall)
		else $error("skid slot emptied without a transfer");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !result_valid)
		else $error("result right after reset");

endmodule

bind triangle_box_overlap_test_unit tbo_checker u_tbo_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.overlap      (overlap)
);
